### design/twv_pkg.sv
// ----------------------------------------------------------------------------
// twv_pkg
// Shared sizes and types for the trapped water volume block.
// ----------------------------------------------------------------------------
package twv_pkg;

    localparam int MAX_COLUMNS   = 1024;
    localparam int HEIGHT_BITS   = 16;
    localparam int POS_BITS      = $clog2(MAX_COLUMNS);
    localparam int CNT_BITS      = $clog2(MAX_COLUMNS + 1);
    localparam int ENTRY_BITS    = POS_BITS + HEIGHT_BITS;
    localparam int WATER_BITS    = 26;
    localparam int PROD_BITS     = POS_BITS + HEIGHT_BITS;
    localparam int ACC_BITS      = ((PROD_BITS > WATER_BITS) ? PROD_BITS : WATER_BITS) + 1;
    localparam int IN_DATA_BITS  = 16;
    localparam int OUT_DATA_BITS = 32;

    localparam logic [WATER_BITS-1:0] WATER_MAX = '1;

    // commands from the stack controller to the water accumulator
    typedef struct packed {
        logic op_valid;
        logic clear;
    } t_acc_cmd;

endpackage

### design/twv_ram.sv
// ----------------------------------------------------------------------------
// twv_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module twv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/twv_accum.sv
// ----------------------------------------------------------------------------
// twv_accum
// Width times depth product stage followed by a saturating water total.
// ----------------------------------------------------------------------------
module twv_accum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  twv_pkg::t_acc_cmd            i_cmd,
    input  logic [twv_pkg::POS_BITS-1:0]    i_width,
    input  logic [twv_pkg::HEIGHT_BITS-1:0] i_depth,
    output logic [twv_pkg::WATER_BITS-1:0]  o_sum,
    output logic                         o_busy
);
    import twv_pkg::*;

    logic [PROD_BITS-1:0]  r_prod;
    logic                  r_prod_valid;
    logic [WATER_BITS-1:0] r_sum;
    logic [ACC_BITS-1:0]   sum_ext;

    assign sum_ext = ACC_BITS'(r_sum) + ACC_BITS'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_sum        <= '0;
        end else begin
            r_prod_valid <= i_cmd.op_valid;
            if (i_cmd.op_valid) begin
                r_prod <= PROD_BITS'(i_width) * PROD_BITS'(i_depth);
            end
            if (i_cmd.clear) begin
                r_sum <= '0;
            end else if (r_prod_valid) begin
                // saturate instead of wrapping
                if (sum_ext > ACC_BITS'(WATER_MAX)) begin
                    r_sum <= WATER_MAX;
                end else begin
                    r_sum <= sum_ext[WATER_BITS-1:0];
                end
            end
        end
    end

    assign o_sum  = r_sum;
    assign o_busy = r_prod_valid;

endmodule

### design/trapped_water_volume.sv
// ----------------------------------------------------------------------------
// trapped_water_volume
// Trapped rain water over a column profile, monotonic stack kept in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   slave channel: one column height per beat in tdata, tlast on the final
//   column of the profile. master channel: one beat per profile, the water
//   total in tdata and the too-long flag in tuser.
//   A column is accepted, then checked against the stack top: each entry it
//   pops takes a compare and then a read of the left neighbour from the
//   stack RAM's registered read port; a pop that empties the stack needs no
//   read. The column is then pushed, and only then is the next one accepted.
//   After the last column, the multiply and saturating add pipeline drains
//   before the result is registered.
//   Each column is pushed once and popped at most once.
//   Columns past MAX_COLUMNS are dropped and set the too-long flag.
//   Reset clears the stack level, position, total and flag at once; no RAM
//   clearing pass is needed since only entries below the level are read.
//   The result sits in an output register; if the receiver stalls, the
//   block finishes the profile and holds the result until it is taken, and
//   the next profile's columns are accepted meanwhile.
// ----------------------------------------------------------------------------
module trapped_water_volume (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // column_height [15:0]
    input  logic [twv_pkg::IN_DATA_BITS-1:0]  i_s_tdata,
    input  logic                              i_s_tlast,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // water_total [25:0], zero fill [31:26]
    output logic [twv_pkg::OUT_DATA_BITS-1:0] o_m_tdata,
    // too_long [0]
    output logic                              o_m_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready
);
    import twv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_LEFT,
        S_FINISH
    } t_state;

    t_state                 r_state;
    logic [CNT_BITS-1:0]    r_level;
    logic [CNT_BITS-1:0]    r_col_pos;
    logic                   r_overflow;
    logic [HEIGHT_BITS-1:0] r_h;
    logic                   r_last;
    logic [HEIGHT_BITS-1:0] r_top_h;
    logic [HEIGHT_BITS-1:0] r_low;
    logic [POS_BITS-1:0]    r_width;
    logic [HEIGHT_BITS-1:0] r_depth;
    logic                   r_op_valid;
    logic                   r_out_valid;
    logic [WATER_BITS-1:0]  r_out_sum;
    logic                   r_out_flag;

    logic                   accept;
    logic                   pop;
    logic                   push_we;
    logic                   busy;
    logic                   emit;
    logic [CNT_BITS-1:0]    lvl_m2;
    logic [ENTRY_BITS-1:0]  wdata;
    logic [ENTRY_BITS-1:0]  rdata;
    logic [POS_BITS-1:0]    left_pos;
    logic [HEIGHT_BITS-1:0] left_h;
    logic [HEIGHT_BITS-1:0] high;
    logic [WATER_BITS-1:0]  acc_sum;
    logic                   acc_busy;
    t_acc_cmd               acc_cmd;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    assign pop     = (r_state == S_CHECK) && (r_level != '0) && (r_h >= r_top_h);
    assign push_we = (r_state == S_CHECK) && !pop && (r_level < CNT_BITS'(MAX_COLUMNS));
    assign lvl_m2  = r_level - CNT_BITS'(2);
    assign wdata   = {r_col_pos[POS_BITS-1:0], r_h};

    assign left_pos = rdata[ENTRY_BITS-1:HEIGHT_BITS];
    assign left_h   = rdata[HEIGHT_BITS-1:0];
    assign high     = (r_h < left_h) ? r_h : left_h;

    assign busy = r_op_valid || acc_busy;
    assign emit = (r_state == S_FINISH) && !busy && (!r_out_valid || i_m_tready);

    assign acc_cmd.op_valid = r_op_valid;
    assign acc_cmd.clear    = emit;

    // write only on push at the level, read at level minus two: the two never hit one entry together
    twv_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (push_we),
        .i_waddr (r_level[POS_BITS-1:0]),
        .i_wdata (wdata),
        .i_raddr (lvl_m2[POS_BITS-1:0]),
        .o_rdata (rdata)
    );

    twv_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (acc_cmd),
        .i_width (r_width),
        .i_depth (r_depth),
        .o_sum   (acc_sum),
        .o_busy  (acc_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_col_pos   <= '0;
            r_overflow  <= 1'b0;
            r_op_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_op_valid <= (r_state == S_LEFT);
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_h    <= i_s_tdata[HEIGHT_BITS-1:0];
                        r_last <= i_s_tlast;
                        if (r_col_pos == CNT_BITS'(MAX_COLUMNS)) begin
                            // profile too long: drop the column
                            r_overflow <= 1'b1;
                            r_state    <= i_s_tlast ? S_FINISH : S_IDLE;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (pop) begin
                        r_low   <= r_top_h;
                        r_level <= r_level - CNT_BITS'(1);
                        // popping the bottom entry leaves no left wall
                        r_state <= (r_level == CNT_BITS'(1)) ? S_CHECK : S_LEFT;
                    end else begin
                        if (push_we) begin
                            r_top_h   <= r_h;
                            r_level   <= r_level + CNT_BITS'(1);
                        end
                        r_col_pos <= r_col_pos + CNT_BITS'(1);
                        r_state   <= r_last ? S_FINISH : S_IDLE;
                    end
                end
                S_LEFT: begin
                    r_width    <= r_col_pos[POS_BITS-1:0] - left_pos - POS_BITS'(1);
                    r_depth    <= high - r_low;
                    r_top_h    <= left_h;
                    r_state    <= S_CHECK;
                end
                S_FINISH: begin
                    if (emit) begin
                        r_out_sum   <= acc_sum;
                        r_out_flag  <= r_overflow;
                        r_level     <= '0;
                        r_col_pos   <= '0;
                        r_overflow  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_BITS'(r_out_sum);
    assign o_m_tuser  = r_out_flag;

`ifndef SYNTHESIS
    a_level_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= r_col_pos)
        else $error("stack deeper than columns taken");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col_pos <= CNT_BITS'(MAX_COLUMNS))
        else $error("column position past limit");

    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_level == '0) && (r_col_pos == '0) && !r_overflow && o_m_tvalid)
        else $error("state not cleared or result missing after emit");

    a_no_op_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> !push_we && !pop)
        else $error("stack access while finishing");
`endif

endmodule
